>>> hw/rtl/sct_pkg.sv
// Shared types, widths and helpers of the sphere collision test pipeline.
package sct_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned MAG_W   = 33;
  localparam int unsigned EXT_W   = 31;
  localparam int unsigned SUMSQ_W = 66;
  localparam int unsigned ROOT_W  = 33;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned DEN_W   = 34;
  localparam int unsigned QUO_W   = 30;
  localparam int unsigned WSQ_W   = 62;
  localparam int unsigned LANES   = 3;

  typedef enum logic [1:0] {
    FUNC_SPHERE = 2'd0,
    FUNC_BOX    = 2'd1,
    FUNC_PLANE  = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [30:0]        rad;
    logic signed [31:0] osc;
    logic               plane_hit;
    logic [31:0]        plane_sep;
  } side_t;

  localparam logic signed [67:0] SAT_MAX = 68'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [67:0] SAT_MIN = -68'sh0_0000_0000_8000_0000;

  function automatic logic [31:0] sat32(input logic signed [67:0] v);
    logic [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'h7FFF_FFFF;
    end else if (v < SAT_MIN) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/sphere_collision_test.sv
// Top level of the sphere collision test pipeline.
// One query enters on the slave stream: tuser carries the other shape kind and
// tdata the tested sphere, the other shape and the box extents. Each query gives
// one result on the master stream: a hit flag and a saturated signed separation.
// Every stage is a register stage; a query may enter in every cycle that the
// receiver does not stall, so the sustained rate is one query per cycle. From
// input transfer to output valid a query passes three front stages (differences
// and products, squares, sums), 30 divider stages for the box scaling, two stages
// that square and sum the scaled extents, 33 square root stages, the result register.
// The whole pipeline advances together; when the receiver stalls a valid
// result, every stage holds and tready falls, so nothing is lost or repeated.
// Reset clears all valid bits; data registers need no reset.
module sphere_collision_test #(
  parameter int unsigned FracBits = sct_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sphere_x, sphere_y, sphere_z, sphere_radius, other_x, other_y, other_z,
  // other_scalar, box_width, box_height, box_depth, then zero fill
  input  logic [351:0] s_axis_tdata,
  // func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit, separation, then zero fill
  output logic [39:0]  m_axis_tdata
);

  localparam int unsigned L   = sct_pkg::LANES;
  localparam int unsigned DQ  = sct_pkg::QUO_W;
  localparam int unsigned SQ  = sct_pkg::ROOT_W;
  localparam int unsigned LAT = 3 + DQ + 2 + SQ + 1;

  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  logic signed [31:0] sc_in [L];
  logic signed [31:0] oc_in [L];
  logic [30:0]        ext_in [L];

  assign sc_in[0]  = s_axis_tdata[31:0];
  assign sc_in[1]  = s_axis_tdata[63:32];
  assign sc_in[2]  = s_axis_tdata[95:64];
  assign oc_in[0]  = s_axis_tdata[158:127];
  assign oc_in[1]  = s_axis_tdata[190:159];
  assign oc_in[2]  = s_axis_tdata[222:191];
  assign ext_in[0] = s_axis_tdata[285:255];
  assign ext_in[1] = s_axis_tdata[316:286];
  assign ext_in[2] = s_axis_tdata[347:317];

  // Stage 1: center differences and plane products.
  logic [1:0]                      func1_q;
  logic [30:0]                     rad1_q;
  logic signed [31:0]              osc1_q;
  logic [sct_pkg::MAG_W-1:0]       m1_q   [L];
  logic signed [63:0]              p1_q   [L];
  logic [sct_pkg::EXT_W-1:0]       ext1_q [L];
  logic [sct_pkg::MAG_W-1:0]       m1_d   [L];
  logic signed [63:0]              p1_d   [L];

  always_comb begin
    logic signed [32:0] diff;
    for (int i = 0; i < L; i++) begin
      diff  = 33'(sc_in[i]) - 33'(oc_in[i]);
      m1_d[i] = diff[32] ? (~diff + 33'd1) : diff;
      p1_d[i] = 64'(oc_in[i]) * 64'(sc_in[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func1_q <= s_axis_tuser;
      rad1_q  <= s_axis_tdata[126:96];
      osc1_q  <= s_axis_tdata[254:223];
      for (int i = 0; i < L; i++) begin
        m1_q[i]   <= m1_d[i];
        p1_q[i]   <= p1_d[i];
        ext1_q[i] <= ext_in[i];
      end
    end
  end

  // Stage 2: squares, scaled products, dominant magnitude, plane sum.
  logic [1:0]                  func2_q;
  logic [30:0]                 rad2_q;
  logic signed [31:0]          osc2_q;
  logic [sct_pkg::SUMSQ_W-1:0] sq2_q   [L];
  logic [sct_pkg::PROD_W-1:0]  prod2_q [L];
  logic [sct_pkg::MAG_W-1:0]   dom2_q;
  logic signed [65:0]          psum2_q;
  logic [sct_pkg::MAG_W-1:0]   dom2_d;

  always_comb begin
    dom2_d = m1_q[0];
    if (m1_q[1] > dom2_d) begin
      dom2_d = m1_q[1];
    end
    if (m1_q[2] > dom2_d) begin
      dom2_d = m1_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      func2_q <= func1_q;
      rad2_q  <= rad1_q;
      osc2_q  <= osc1_q;
      dom2_q  <= dom2_d;
      psum2_q <= 66'(p1_q[0]) + 66'(p1_q[1]) + 66'(p1_q[2]);
      for (int i = 0; i < L; i++) begin
        sq2_q[i]   <= 66'(m1_q[i]) * 66'(m1_q[i]);
        prod2_q[i] <= 64'(m1_q[i]) * 64'(ext1_q[i]);
      end
    end
  end

  // Stage 3: squared distance and the finished plane result.
  sct_pkg::side_t              side3_q;
  logic [sct_pkg::SUMSQ_W-1:0] sumsq3_q;
  logic [sct_pkg::PROD_W-1:0]  prod3_q [L];
  logic [sct_pkg::DEN_W-1:0]   den3_q;
  logic signed [65:0]          dot3;
  logic signed [67:0]          e3;

  assign dot3 = psum2_q >>> FracBits;
  assign e3   = 68'(dot3) - 68'(osc2_q) - 68'($signed({1'b0, rad2_q}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q.func      <= func2_q;
      side3_q.rad       <= rad2_q;
      side3_q.osc       <= osc2_q;
      side3_q.plane_hit <= e3[67];
      side3_q.plane_sep <= sct_pkg::sat32(e3);
      sumsq3_q          <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      den3_q            <= {dom2_q, 1'b0};
      for (int i = 0; i < L; i++) begin
        prod3_q[i] <= prod2_q[i];
      end
    end
  end

  // Box scaling divider, with the rest of the query delayed alongside.
  logic [sct_pkg::QUO_W-1:0]   quo [L];
  sct_pkg::side_t              dside_q  [DQ];
  logic [sct_pkg::SUMSQ_W-1:0] dsumsq_q [DQ];

  sct_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (prod3_q),
    .den_i (den3_q),
    .quo_o (quo)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dside_q[0]  <= side3_q;
      dsumsq_q[0] <= sumsq3_q;
      for (int k = 1; k < DQ; k++) begin
        dside_q[k]  <= dside_q[k-1];
        dsumsq_q[k] <= dsumsq_q[k-1];
      end
    end
  end

  // Stages 4 and 5: squared and summed scaled extents.
  sct_pkg::side_t              side4_q, side5_q;
  logic [sct_pkg::SUMSQ_W-1:0] sumsq4_q, sumsq5_q;
  logic [59:0]                 wsq4_q [L];
  logic [sct_pkg::WSQ_W-1:0]   wsum5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side4_q  <= dside_q[DQ-1];
      sumsq4_q <= dsumsq_q[DQ-1];
      for (int i = 0; i < L; i++) begin
        wsq4_q[i] <= 60'(quo[i]) * 60'(quo[i]);
      end
      side5_q  <= side4_q;
      sumsq5_q <= sumsq4_q;
      wsum5_q  <= 62'(wsq4_q[0]) + 62'(wsq4_q[1]) + 62'(wsq4_q[2]);
    end
  end

  // Two square roots side by side: center distance and scaled box length.
  logic [sct_pkg::ROOT_W-1:0] cdist;
  logic [sct_pkg::ROOT_W-1:0] blen;
  sct_pkg::side_t             rside_q [SQ];

  sct_isqrt u_sqrt_dist (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sumsq5_q),
    .root_o (cdist)
  );

  sct_isqrt u_sqrt_box (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sct_pkg::SUMSQ_W'(wsum5_q)),
    .root_o (blen)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      rside_q[0] <= side5_q;
      for (int k = 1; k < SQ; k++) begin
        rside_q[k] <= rside_q[k-1];
      end
    end
  end

  // Result stage.
  sct_pkg::side_t     rs;
  logic signed [34:0] sdist;
  logic signed [34:0] rsum;
  logic signed [34:0] blim;
  logic               hit_d;
  logic [31:0]        sep_d;
  logic               hit_q;
  logic [31:0]        sep_q;
  logic [1:0]         func_q;

  assign rs    = rside_q[SQ-1];
  assign sdist = $signed({2'b00, cdist});
  assign rsum  = 35'($signed({1'b0, rs.rad})) + 35'($signed(rs.osc));
  assign blim  = 35'($signed({1'b0, rs.rad})) + 35'($signed({1'b0, blen}));

  always_comb begin
    hit_d = 1'b0;
    sep_d = '0;
    case (rs.func)
      sct_pkg::FUNC_SPHERE: begin
        if (sdist <= rsum) begin
          hit_d = 1'b1;
          sep_d = sct_pkg::sat32(68'(sdist - rsum));
        end
      end
      sct_pkg::FUNC_BOX: begin
        if (cdist == '0) begin
          hit_d = 1'b1;
        end else begin
          hit_d = sdist <= blim;
          sep_d = sct_pkg::sat32(68'(sdist));
        end
      end
      sct_pkg::FUNC_PLANE: begin
        hit_d = rs.plane_hit;
        sep_d = rs.plane_sep;
      end
      default: begin
        hit_d = 1'b0;
        sep_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      sep_q  <= sep_d;
      func_q <= rs.func;
    end
  end

  assign m_axis_tdata = {7'd0, sep_q, hit_q};

  a_sphere_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && func_q == sct_pkg::FUNC_SPHERE && !hit_q |-> sep_q == '0)
    else $error("sphere miss with nonzero separation");

  a_sphere_hit_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && func_q == sct_pkg::FUNC_SPHERE && hit_q |-> sep_q[31] || sep_q == '0)
    else $error("sphere hit with positive separation");

  a_plane_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && func_q == sct_pkg::FUNC_PLANE |-> hit_q == sep_q[31])
    else $error("plane hit disagrees with separation sign");

  a_box_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && func_q == sct_pkg::FUNC_BOX |-> !sep_q[31])
    else $error("box separation is negative");

endmodule

>>> hw/rtl/sct_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module sct_isqrt (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [sct_pkg::SUMSQ_W-1:0]      rad_i,
  output logic [sct_pkg::ROOT_W-1:0]       root_o
);

  localparam int unsigned W = sct_pkg::SUMSQ_W + 1;
  localparam int unsigned N = sct_pkg::ROOT_W;

  logic [W-1:0] rem_q  [N];
  logic [N-1:0] root_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned B = N - 1 - k;
    logic [W-1:0] rem_in, trial, rem_d;
    logic [N-1:0] root_in, root_d;

    if (k == 0) begin : g_first
      assign rem_in  = W'(rad_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    always_comb begin
      trial = (W'(root_in) << (B + 1)) | (W'(1) << (2 * B));
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (N'(1) << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

>>> hw/rtl/sct_div.sv
// Pipelined three-lane restoring divider with a shared divisor, one quotient bit per stage.
module sct_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sct_pkg::PROD_W-1:0]    num_i [sct_pkg::LANES],
  input  logic [sct_pkg::DEN_W-1:0]     den_i,
  output logic [sct_pkg::QUO_W-1:0]     quo_o [sct_pkg::LANES]
);

  localparam int unsigned N = sct_pkg::QUO_W;
  localparam int unsigned W = sct_pkg::PROD_W;
  localparam int unsigned L = sct_pkg::LANES;

  logic [W-1:0]               rem_q [N][L];
  logic [N-1:0]               quo_q [N][L];
  logic [sct_pkg::DEN_W-1:0]  den_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned B = N - 1 - k;
    logic [W-1:0]              rem_in [L];
    logic [W-1:0]              rem_d  [L];
    logic [N-1:0]              quo_in [L];
    logic [N-1:0]              quo_d  [L];
    logic [sct_pkg::DEN_W-1:0] den_in;
    logic [W-1:0]              sub;

    if (k == 0) begin : g_first
      assign den_in = den_i;
      for (genvar j = 0; j < L; j++) begin : g_lane
        assign rem_in[j] = num_i[j];
        assign quo_in[j] = '0;
      end
    end else begin : g_next
      assign den_in = den_q[k-1];
      for (genvar j = 0; j < L; j++) begin : g_lane
        assign rem_in[j] = rem_q[k-1][j];
        assign quo_in[j] = quo_q[k-1][j];
      end
    end

    always_comb begin
      sub = W'(den_in) << B;
      for (int j = 0; j < L; j++) begin
        if (rem_in[j] >= sub) begin
          rem_d[j] = rem_in[j] - sub;
          quo_d[j] = quo_in[j] | (N'(1) << B);
        end else begin
          rem_d[j] = rem_in[j];
          quo_d[j] = quo_in[j];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
        for (int j = 0; j < L; j++) begin
          rem_q[k][j] <= rem_d[j];
          quo_q[k][j] <= quo_d[j];
        end
      end
    end
  end

  for (genvar j = 0; j < L; j++) begin : g_out
    assign quo_o[j] = quo_q[N-1][j];
  end

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench of the sphere collision test pipeline.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LATENCY   = 69;
  localparam int unsigned NUM_RAND  = 400;
  localparam longint      CYCLE_MAX = 200000;

  typedef struct {
    sct_pkg::func_e     func;
    logic signed [31:0] sx, sy, sz;
    logic [30:0]        rad;
    logic signed [31:0] ox, oy, oz, osc;
    logic [30:0]        bw, bh, bd;
  } query_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] sep;
  } contact_t;

  typedef struct {
    query_t q;
    logic   known;
    contact_t c;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [351:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;

  contact_t    contact_q[$];
  int          errors = 0;
  longint      cycles = 0;
  logic        stim_done = 1'b0;
  int unsigned ready_wait = 0;

  sphere_collision_test i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [67:0] isqrt(input logic [67:0] n);
    logic [67:0] r;
    logic [67:0] c;
    logic [71:0] sq;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (68'd1 << b);
      sq = 72'(c) * 72'(c);
      if (sq <= 72'(n)) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [67:0] floor16(input logic signed [67:0] p);
    return p >>> 16;
  endfunction

  function automatic contact_t predict_contact(input query_t q);
    contact_t c;
    logic signed [67:0] dv[3];
    logic [67:0] m[3], ext[3], w[3], d, dom, l;
    logic signed [67:0] s, e, p, h, hs, ls;
    c.hit = 1'b0;
    c.sep = '0;
    dv[0] = 68'(q.sx) - 68'(q.ox);
    dv[1] = 68'(q.sy) - 68'(q.oy);
    dv[2] = 68'(q.sz) - 68'(q.oz);
    for (int i = 0; i < 3; i++) m[i] = dv[i] < 0 ? -dv[i] : dv[i];
    ext[0] = 68'(q.bw);
    ext[1] = 68'(q.bh);
    ext[2] = 68'(q.bd);
    d = isqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    case (q.func)
      sct_pkg::FUNC_SPHERE: begin
        s = 68'(q.rad) + 68'(q.osc);
        if ($signed(d) <= s) begin
          c.hit = 1'b1;
          c.sep = sct_pkg::sat32($signed(d) - s);
        end
      end
      sct_pkg::FUNC_BOX: begin
        if (d == '0) begin
          c.hit = 1'b1;
        end else begin
          dom = m[0];
          if (m[1] > dom) dom = m[1];
          if (m[2] > dom) dom = m[2];
          for (int i = 0; i < 3; i++) w[i] = (m[i] * ext[i]) / (68'd2 * dom);
          l = isqrt(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]);
          c.hit = d <= 68'(q.rad) + l;
          c.sep = sct_pkg::sat32($signed(d));
        end
      end
      sct_pkg::FUNC_PLANE: begin
        hs = '0;
        ls = '0;
        for (int i = 0; i < 3; i++) begin
          p = i == 0 ? 68'(q.ox) * 68'(q.sx) :
              i == 1 ? 68'(q.oy) * 68'(q.sy) : 68'(q.oz) * 68'(q.sz);
          h = floor16(p);
          hs += h;
          ls += p - (h <<< 16);
        end
        e = hs + floor16(ls) - 68'(q.osc) - 68'(q.rad);
        c.hit = e < 0;
        c.sep = sct_pkg::sat32(e);
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int unsigned k;
    q.func = sct_pkg::func_e'($urandom_range(0, 3));
    k = $urandom_range(0, 3);
    q.sx = $urandom; q.sy = $urandom; q.sz = $urandom; q.rad = 31'($urandom);
    q.ox = $urandom; q.oy = $urandom; q.oz = $urandom; q.osc = $urandom;
    q.bw = 31'($urandom); q.bh = 31'($urandom); q.bd = 31'($urandom);
    if (k != 0) begin
      // Keep most queries near the other shape so that hits and misses both occur.
      q.sx = $signed(q.sx) >>> (8 + 4 * k);
      q.sy = $signed(q.sy) >>> (8 + 4 * k);
      q.sz = $signed(q.sz) >>> (8 + 4 * k);
      q.rad = q.rad >> (8 + 4 * k);
      q.ox = $signed(q.ox) >>> (8 + 4 * k);
      q.oy = $signed(q.oy) >>> (8 + 4 * k);
      q.oz = $signed(q.oz) >>> (8 + 4 * k);
      q.osc = $signed(q.osc) >>> (8 + 4 * k);
      q.bw = q.bw >> (6 + 4 * k);
      q.bh = q.bh >> (6 + 4 * k);
      q.bd = q.bd >> (6 + 4 * k);
      if (q.func == sct_pkg::FUNC_PLANE && $urandom_range(0, 1)) begin
        q.ox = 32'sh0001_0000 >>> $urandom_range(0, 2);
        q.oy = $signed(32'($urandom_range(0, 65536))) - 32'sd32768;
        q.oz = '0;
      end
      if (q.func == sct_pkg::FUNC_BOX && $urandom_range(0, 7) == 0) begin
        q.ox = q.sx; q.oy = q.sy; q.oz = q.sz;
      end
    end
    return q;
  endfunction

  task automatic send_query(input query_t q);
    int unsigned gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    contact_q.push_back(predict_contact(q));
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.func;
    s_axis_tdata  <= {4'd0, q.bd, q.bh, q.bw, q.osc, q.oz, q.oy, q.ox,
                      q.rad, q.sz, q.sy, q.sx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic query_t make_query(input sct_pkg::func_e f,
                                        input logic signed [31:0] sx,
                                        input logic [30:0] rad, input logic signed [31:0] ox,
                                        input logic signed [31:0] osc, input logic [30:0] ext);
    query_t q;
    q.func = f;
    q.sx = sx; q.sy = '0; q.sz = '0; q.rad = rad;
    q.ox = ox; q.oy = '0; q.oz = '0; q.osc = osc;
    q.bw = ext; q.bh = ext; q.bd = ext;
    return q;
  endfunction

  initial begin
    row_t   rows[$];
    row_t   r;
    query_t q;
    contact_t exp_c;
    r.known = 1'b1;
    r.q = make_query(sct_pkg::FUNC_SPHERE, '0, '0, '0, '0, '0);
    r.c = '{1'b1, 32'sd0}; rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_BOX, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, '0,
                     31'h7FFF_FFFF);
    r.c = '{1'b1, 32'sd0}; rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_PLANE, '0, '0, '0, '0, '0);
    r.c = '{1'b0, 32'sd0}; rows.push_back(r);
    r.q = make_query(sct_pkg::func_e'(2'd3), 32'sh7FFF_FFFF, 31'h7FFF_FFFF, -32'sh8000_0000,
                     -32'sh8000_0000, 31'h7FFF_FFFF);
    r.c = '{1'b0, 32'sd0}; rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_SPHERE, 32'sh0003_0000, 31'h1_0000, '0, 32'sh2_0000, '0);
    r.c = '{1'b1, 32'sd0}; rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_SPHERE, 32'sh0004_0000, 31'h1_0000, '0, 32'sh2_0000, '0);
    r.c = '{1'b0, 32'sd0}; rows.push_back(r);
    r.known = 1'b0;
    r.q = make_query(sct_pkg::FUNC_SPHERE, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, -32'sh8000_0000,
                     32'sh7FFF_FFFF, '0); rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_SPHERE, 32'sh1000, '0, '0, -32'sh8000_0000, '0);
    rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_BOX, -32'sh8000_0000, '0, 32'sh7FFF_FFFF, '0,
                     31'h7FFF_FFFF);
    rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_BOX, 32'sh5_0000, 31'h1_0000, '0, '0, 31'h8_0000);
    rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_BOX, 32'sh5_0000, 31'h1_0000, '0, '0, 31'h6_0000);
    rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_PLANE, -32'sh8000_0000, 31'h7FFF_FFFF, -32'sh8000_0000,
                     -32'sh8000_0000, '0); rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_PLANE, -32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, '0); rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_PLANE, -32'sd3, '0, 32'sh8000, '0, '0); rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_PLANE, 32'sh3_0000, 31'h1_0000, 32'sh1_0000, 32'sh2_0000,
                     '0);
    rows.push_back(r);
    r.q = make_query(sct_pkg::FUNC_BOX, 32'sh1, '0, '0, '0, 31'h7FFF_FFFF);
    r.q.sy = -32'sh1; r.q.oz = 32'sh1; rows.push_back(r);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send_query(rows[i].q);
      if (rows[i].known) begin
        exp_c = predict_contact(rows[i].q);
        if (exp_c != rows[i].c) begin
          $error("row %0d: table hit=%0d sep=%0d, predictor hit=%0d sep=%0d", i,
                 rows[i].c.hit, rows[i].c.sep, exp_c.hit, exp_c.sep);
          errors++;
        end
        contact_q[$] = rows[i].c;
      end
    end
    for (int n = 0; n < NUM_RAND; n++) begin
      if (n == NUM_RAND / 2) begin
        s_axis_tvalid <= 1'b0;
        wait (contact_q.size() == 0);
      end
      q = random_query();
      send_query(q);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  always @(posedge clk_i) begin
    contact_t exp_c;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (contact_q.size() == 0) begin
          $error("unexpected transfer on the result stream");
          errors++;
        end else begin
          exp_c = contact_q.pop_front();
          if (m_axis_tdata[0] !== exp_c.hit) begin
            $error("hit: expected %0d, actual %0d", exp_c.hit, m_axis_tdata[0]);
            errors++;
          end
          if ($signed(m_axis_tdata[32:1]) !== exp_c.sep) begin
            $error("separation: expected %0d, actual %0d", exp_c.sep,
                   $signed(m_axis_tdata[32:1]));
            errors++;
          end
        end
        ready_wait = $urandom_range(0, 4);
      end
      if (ready_wait != 0) begin
        ready_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    wait (stim_done && contact_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

>>> files.f
hw/rtl/sct_pkg.sv
hw/rtl/sct_isqrt.sv
hw/rtl/sct_div.sv
hw/rtl/sphere_collision_test.sv
tb/sv/tb.sv
